// File: design/skis_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key set package
// Shared constants and the link type passed between neighbouring cells.
// ----------------------------------------------------------------------------
package skis_pkg;

    localparam int DefCapacity = 64;
    localparam int KeyW        = 32;
    localparam int CntOutW     = 7;
    localparam int GroupSize   = 64;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_FIND   = 1'b1;

    typedef struct packed {
        logic            valid;
        logic            sel;
        logic [KeyW-1:0] key;
    } t_cell_link;

endpackage

// File: design/skis_cell.sv
// ----------------------------------------------------------------------------
// Sorted key set cell
// Holds one key with its valid flag, compares it against the request key and
// takes either its own old key, its neighbour's key or the new key on insert.
// ----------------------------------------------------------------------------
module skis_cell
    import skis_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_link      i_prev,
    input  logic            i_cmp,
    input  logic            i_ins,
    input  logic [KeyW-1:0] i_key,
    output t_cell_link      o_link,
    output logic            o_hit
);

    logic            r_valid;
    logic            r_sel;
    logic            r_hit;
    logic [KeyW-1:0] r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_cmp) begin
                r_sel <= !r_valid || (r_key > i_key);
                r_hit <= r_valid && (r_key == i_key);
            end
            if (i_ins) begin
                r_valid <= r_valid | i_prev.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ins) begin
            if (i_prev.sel) begin
                r_key <= i_prev.key;
            end else if (r_sel) begin
                r_key <= i_key;
            end
        end
    end

    assign o_link = '{valid: r_valid, sel: r_sel, key: r_key};
    assign o_hit  = r_hit;

endmodule

// File: design/sorted_key_set_insert_lookup.sv
// ----------------------------------------------------------------------------
// Sorted key set with insert and lookup
// Keeps keys in ascending order in a row of compare-and-shift cells.
//
// Channel  | Handshake        | Fields
// request  | start / busy     | i_func, i_key_value
// result   | o_valid (strobe) | o_found, o_match_value, o_accepted, o_entry_count
//
// The key is latched at the accepting edge; then every cell compares, then the
// cells shift on an insert while the hit flags are reduced by groups, and then
// the result is registered and the result strobe rises.
// A new request may be accepted in the cycle in which the result is shown, but
// no new request is taken while the last one is still in progress.
// Reset empties the set at once; no clearing pass is needed.
// The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module sorted_key_set_insert_lookup
    import skis_pkg::*;
#(
    parameter int Capacity = DefCapacity
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_func,
    input  logic [KeyW-1:0]     i_key_value,
    output logic                o_valid,
    output logic                o_found,
    output logic [KeyW-1:0]     o_match_value,
    output logic                o_accepted,
    output logic [CntOutW-1:0]  o_entry_count
);

    localparam int CntW  = $clog2(Capacity + 1);
    localparam int NGrp  = (Capacity + GroupSize - 1) / GroupSize;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CMP   = 4'b0010,
        ST_APPLY = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic              r_func;
    logic [KeyW-1:0]   r_key;
    logic [CntW-1:0]   r_count;
    logic              r_acc;
    logic [NGrp-1:0]   r_grp;
    logic [NGrp-1:0]   w_grp;
    logic              w_full;
    logic              w_ins;
    logic              w_cmp;
    logic [CntW+CntOutW-1:0] w_cnt_ext;

    t_cell_link        w_link [Capacity+1];
    logic [Capacity-1:0] w_hit;

    assign w_full = (r_count == CntW'(Capacity));
    assign w_cmp  = (r_state == ST_CMP);
    assign w_ins  = (r_state == ST_APPLY) && (r_func == FUNC_INSERT) && !w_full;
    assign busy   = (r_state != ST_IDLE);

    assign w_link[0] = '{valid: 1'b1, sel: 1'b0, key: '0};

    for (genvar gi = 0; gi < Capacity; gi++) begin : g_cell
        skis_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_prev  (w_link[gi]),
            .i_cmp   (w_cmp),
            .i_ins   (w_ins),
            .i_key   (r_key),
            .o_link  (w_link[gi+1]),
            .o_hit   (w_hit[gi])
        );
    end

    always_comb begin
        w_grp = '0;
        for (int g = 0; g < NGrp; g++) begin
            for (int j = 0; j < GroupSize; j++) begin
                if (g * GroupSize + j < Capacity) begin
                    w_grp[g] = w_grp[g] | w_hit[g * GroupSize + j];
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_CMP;
            ST_CMP:   n_state = ST_APPLY;
            ST_APPLY: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_acc   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == ST_DONE);
            if (r_state == ST_APPLY) begin
                r_acc <= w_ins;
            end
            if (w_ins) begin
                r_count <= r_count + CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_func <= i_func;
            r_key  <= i_key_value;
        end
        if (r_state == ST_APPLY) begin
            r_grp <= w_grp;
        end
        if (r_state == ST_DONE) begin
            o_found       <= (r_func == FUNC_FIND) && (|r_grp);
            o_match_value <= ((r_func == FUNC_FIND) && (|r_grp)) ? r_key : '0;
            o_accepted    <= (r_func == FUNC_INSERT) && r_acc;
            o_entry_count <= w_cnt_ext[CntOutW-1:0];
        end
    end

    assign w_cnt_ext = {{CntOutW{1'b0}}, r_count};

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_found && o_accepted))
        else $error("Result reports both a hit and an accepted insert.");

    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(Capacity))
        else $error("Stored count exceeds the capacity.");

    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> (o_valid && r_state == ST_IDLE))
        else $error("Result strobe missing after a request completed.");

    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_match_value == r_key))
        else $error("Hit returns a key other than the requested one.");

    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins |=> (r_count == $past(r_count) + CntW'(1)))
        else $error("Insert did not advance the stored count.");

endmodule

// File: verif/sorted_key_set_insert_lookup_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted key set testbench
// Sends insert and find requests with random spacing, keeps its own ordered
// copy of the stored keys to predict every result, and checks each result
// strobe field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sorted_key_set_insert_lookup_tb;
    import skis_pkg::*;

    localparam int NumRandom   = 530;
    localparam int IdleLimit   = 2000;
    localparam int DrainCycles = 8;
    localparam int NumDirected = 22;

    localparam logic [KeyW:0] Directed [0:NumDirected-1] = '{
        {FUNC_FIND,   32'h0000_0000}, {FUNC_FIND,   32'hFFFF_FFFF},
        {FUNC_INSERT, 32'h8000_0000}, {FUNC_INSERT, 32'h0000_0000},
        {FUNC_INSERT, 32'hFFFF_FFFF}, {FUNC_INSERT, 32'h8000_0000},
        {FUNC_INSERT, 32'h0000_0000}, {FUNC_FIND,   32'h0000_0000},
        {FUNC_FIND,   32'hFFFF_FFFF}, {FUNC_FIND,   32'h8000_0000},
        {FUNC_FIND,   32'h7FFF_FFFF}, {FUNC_FIND,   32'h8000_0001},
        {FUNC_INSERT, 32'h7FFF_FFFF}, {FUNC_INSERT, 32'h0000_0001},
        {FUNC_FIND,   32'h0000_0001}, {FUNC_FIND,   32'h0000_0002},
        {FUNC_INSERT, 32'hAAAA_AAAA}, {FUNC_INSERT, 32'h5555_5555},
        {FUNC_FIND,   32'hAAAA_AAAA}, {FUNC_FIND,   32'h5555_5555},
        {FUNC_FIND,   32'h7FFF_FFFF}, {FUNC_FIND,   32'hFFFF_FFFE}
    };

    typedef struct {
        logic               found;
        logic [KeyW-1:0]    match_value;
        logic               accepted;
        logic [CntOutW-1:0] entry_count;
    } t_outcome;

    class sorted_set_tracker;
        logic [KeyW-1:0] keys[$];
        t_outcome        due[$];
        int errors, inserts, refusals, finds, hits, results;

        function void note_request(logic func, logic [KeyW-1:0] key);
            t_outcome outcome;
            int       pos;
            outcome.found       = 1'b0;
            outcome.match_value = '0;
            outcome.accepted    = 1'b0;
            if (func == FUNC_INSERT) begin
                inserts++;
                if (keys.size() < DefCapacity) begin
                    pos = keys.size();
                    while (pos > 0 && keys[pos-1] > key) pos--;
                    keys.insert(pos, key);
                    outcome.accepted = 1'b1;
                end else begin
                    refusals++;
                end
            end else begin
                finds++;
                foreach (keys[i]) begin
                    if (keys[i] == key) outcome.found = 1'b1;
                end
                if (outcome.found) begin
                    hits++;
                    outcome.match_value = key;
                end
            end
            outcome.entry_count = CntOutW'(keys.size());
            due.push_back(outcome);
        endfunction

        function void compare_field(string field, logic [KeyW-1:0] want,
                                    logic [KeyW-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            end
        endfunction

        function void check_result(logic found, logic [KeyW-1:0] match_value,
                                   logic accepted, logic [CntOutW-1:0] entry_count);
            t_outcome want;
            results++;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding, expected none actual %h",
                         $time, match_value);
            end else begin
                want = due.pop_front();
                compare_field("found", KeyW'(want.found), KeyW'(found));
                compare_field("match_value", want.match_value, match_value);
                compare_field("accepted", KeyW'(want.accepted), KeyW'(accepted));
                compare_field("entry_count", KeyW'(want.entry_count), KeyW'(entry_count));
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_func;
    logic [KeyW-1:0]    i_key_value;
    logic               o_valid;
    logic               o_found;
    logic [KeyW-1:0]    o_match_value;
    logic               o_accepted;
    logic [CntOutW-1:0] o_entry_count;

    sorted_set_tracker tracker;
    int                idle_cycles;

    sorted_key_set_insert_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_key_value   (i_key_value),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_match_value (o_match_value),
        .o_accepted    (o_accepted),
        .o_entry_count (o_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            tracker.check_result(o_found, o_match_value, o_accepted, o_entry_count);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("%0t: no request or result for %0d cycles", $time, IdleLimit);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The request stays raised across back-to-back requests, so start is only
    // lowered when a gap is wanted.
    task automatic send_request(input logic func, input logic [KeyW-1:0] key, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_func      <= func;
        i_key_value <= key;
        do @(posedge i_clk); while (busy);
        tracker.note_request(func, key);
    endtask

    function automatic logic [KeyW-1:0] pick_key(input logic func);
        logic [KeyW-1:0] stored;
        logic [KeyW-1:0] key;
        int              sel;
        sel = $urandom_range(0, 9);
        if (tracker.keys.size() != 0) begin
            stored = tracker.keys[$urandom_range(0, tracker.keys.size() - 1)];
        end else begin
            stored = $urandom;
        end
        if (func == FUNC_FIND) begin
            case (sel)
                0, 1, 2, 3, 4: key = stored;
                5:             key = stored + 1;
                6:             key = stored - 1;
                7:             key = $urandom_range(0, 1) ? '1 : '0;
                8:             key = $urandom_range(0, 15);
                default:       key = $urandom;
            endcase
        end else begin
            case (sel)
                0, 1:    key = $urandom_range(0, 15);
                2:       key = $urandom_range(0, 1) ? '1 : '0;
                3:       key = stored;
                default: key = $urandom;
            endcase
        end
        return key;
    endfunction

    initial begin
        logic func;
        bit   steady;
        tracker     = new();
        steady      = 1'b0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_func      <= FUNC_INSERT;
        i_key_value <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < NumDirected; n++) begin
            send_request(Directed[n][KeyW], Directed[n][KeyW-1:0], $urandom_range(0, 11));
        end

        for (int n = 0; n < NumRandom; n++) begin
            if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
            func = ($urandom_range(0, 99) < 16) ? FUNC_INSERT : FUNC_FIND;
            send_request(func, pick_key(func), steady ? 0 : $urandom_range(0, 11));
        end
        start <= 1'b0;

        while (tracker.due.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Ran %0d inserts (%0d refused on a full set) and %0d finds (%0d hits).",
                 tracker.inserts, tracker.refusals, tracker.finds, tracker.hits);
        $display("Checked %0d results, %0d mismatches.", tracker.results, tracker.errors);
        if (tracker.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
